// ===== rtl/core/skf_pkg.sv =====
`default_nettype none
package skf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int EST_W      = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int VAR_W      = EST_W - 1;

    localparam logic [16:0] ONE_Q16  = 17'd65536;
    localparam logic [33:0] LN2_Q32  = 34'd2977044472;
    localparam logic [41:0] QUAD_CAP = 42'd1099511627776;

    typedef enum logic [2:0] {
        REG_TRANSITION = 3'd0,
        REG_STATE_NOISE = 3'd1,
        REG_OBS_NOISE = 3'd2,
        REG_INIT_STATE = 3'd3,
        REG_INIT_VAR = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AP,
        ST_AP_W,
        ST_TP_W,
        ST_PP,
        ST_PP_W,
        ST_S,
        ST_S_W,
        ST_KDIV,
        ST_FA,
        ST_FA_W,
        ST_FV_W,
        ST_QDIV,
        ST_NORM,
        ST_SQ,
        ST_SQ_W,
        ST_LN,
        ST_LN_W,
        ST_SUM,
        ST_FIN
    } t_state;

    // rescale a q16.16 product, rounding half up
    function automatic logic signed [67:0] rnd16(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = p + 68'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic [31:0] sat_est(input logic signed [67:0] x);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = (68'sd1 <<< (EST_W - 1)) - 68'sd1;
        lo = -hi - 68'sd1;
        if (x > hi) return hi[31:0];
        else if (x < lo) return lo[31:0];
        else return x[31:0];
    endfunction

    function automatic logic [30:0] sat_var(input logic signed [67:0] x);
        logic signed [67:0] hi;
        hi = (68'sd1 <<< VAR_W) - 68'sd1;
        if (x > hi) return hi[30:0];
        else if (x < 68'sd0) return 31'd0;
        else return x[30:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/skf_obs_if.sv =====
`default_nettype none
interface skf_obs_if;
    logic        valid;
    logic        ready;
    logic [31:0] obs;
    logic        restart;

    modport source (output valid, output obs, output restart, input ready);
    modport sink (input valid, input obs, input restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/skf_res_if.sv =====
`default_nettype none
interface skf_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] predicted_state;
    logic [30:0] predicted_var;
    logic [31:0] filtered_state;
    logic [30:0] filtered_var;
    logic [16:0] gain;
    logic [31:0] lik_term;
    logic [47:0] log_likelihood;
    logic        div_error;

    modport source (output valid, output predicted_state, output predicted_var,
        output filtered_state, output filtered_var, output gain, output lik_term,
        output log_likelihood, output div_error, input ready);
    modport sink (input valid, input predicted_state, input predicted_var,
        input filtered_state, input filtered_var, input gain, input lik_term,
        input log_likelihood, input div_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/scalar_kalman_filter_channel.sv =====
// One channel of a diagonal Kalman filter in Q16.16 fixed point.
// i_obs carries one observation beat (obs, restart); o_res returns one result
// beat per observation: predicted and filtered state and variance, gain,
// likelihood term, running log-likelihood and a zero-variance error flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); write
// it only while no observation is in flight.
// i_obs.ready stays low from accept until the result is loaded into the output
// register. How long a step runs is set by the single shared 34x34 multiplier and
// the one-bit-per-cycle restoring divider: 17 steps for the gain, 64 for e*e/S,
// up to 32 for normalising S and 16 squarings on the multiplier for the log2.
// When S is zero the step skips the divisions and the log2 and goes to the result.
// After reset the coefficients take their default values and the first
// observation loads the initial state and variance as if restart were set.
// The result sits in an output register; while the receiver stalls the next
// observation may already be accepted and worked on, and it waits at its last
// step until the output register frees up.
`default_nettype none
module scalar_kalman_filter_channel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    skf_obs_if.sink          i_obs,
    skf_res_if.source        o_res
);
    import skf_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic signed [31:0] r_t;
    logic [30:0]        r_q;
    logic [30:0]        r_h;
    logic signed [31:0] r_a0;
    logic [30:0]        r_p0;

    // filter state
    logic signed [31:0] r_est;
    logic [30:0]        r_var;
    logic signed [47:0] r_sum;
    logic               r_primed;

    // working registers
    logic signed [31:0] r_z;
    logic signed [31:0] r_ap;
    logic [30:0]        r_tp;
    logic [30:0]        r_pp;
    logic signed [32:0] r_e;
    logic [31:0]        r_s;
    logic [63:0]        r_sq;
    logic [16:0]        r_k;
    logic signed [31:0] r_fa;
    logic [30:0]        r_fv;
    logic [40:0]        r_qd;
    logic signed [31:0] r_term;
    logic               r_err;
    logic [31:0]        r_m;
    logic [4:0]         r_n;
    logic [15:0]        r_f;
    logic [6:0]         r_cnt;

    // shared divider
    logic [31:0] r_rem;
    logic [63:0] r_dvd;
    logic [40:0] r_quo;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] r_prod;

    // output register
    logic        r_out_valid;
    logic [31:0] r_o_ap, r_o_fa, r_o_term;
    logic [30:0] r_o_pp, r_o_fv;
    logic [16:0] r_o_k;
    logic [47:0] r_o_ll;
    logic        r_o_err;

    logic        accept, out_load;
    logic [32:0] abs_t;
    logic [32:0] abs_e;
    logic [32:0] div_try;
    logic        div_bit;
    logic [41:0] quo_next;
    logic [47:0] k_num;
    logic signed [4:0]  n_m16;
    logic signed [20:0] l2;
    logic [20:0]        abs_l2;
    logic [31:0]        sq_top;
    logic signed [67:0] pp_sum;
    logic signed [67:0] fv_rnd;
    logic signed [67:0] ln_val;
    logic signed [67:0] term_sum;
    logic signed [48:0] sum_next;
    logic signed [48:0] neg_sum;

    assign accept   = i_obs.valid && i_obs.ready;
    assign out_load = (r_state == ST_FIN) && (!r_out_valid || o_res.ready);

    assign abs_t = r_t[31] ? (33'd0 - {1'b1, r_t}) : {1'b0, r_t};
    assign abs_e = r_e[32] ? (33'd0 - r_e) : r_e;

    assign div_try  = {r_rem, r_dvd[63]};
    assign div_bit  = div_try >= {1'b0, r_s};
    assign quo_next = ({r_quo, div_bit} > QUAD_CAP) ? QUAD_CAP : {r_quo, div_bit};

    assign k_num  = {1'b0, r_pp, 16'd0} + {17'd0, r_s[31:1]};
    assign n_m16  = $signed(r_n) - 5'sd16;
    assign l2     = $signed({n_m16, r_f});
    assign abs_l2 = l2[20] ? (21'd0 - l2) : l2;
    assign sq_top = r_prod[61:30];

    assign pp_sum   = $signed({37'd0, sat_var(rnd16(r_prod))}) + $signed({37'd0, r_q});
    assign fv_rnd   = rnd16(r_prod);
    assign ln_val   = (r_prod + 68'sd2147483648) >>> 32;
    assign term_sum = (r_f[0] ? -ln_val : ln_val) + $signed({27'd0, r_qd});
    assign sum_next = $signed({r_sum[47], r_sum}) + $signed({{17{r_term[31]}}, r_term});
    assign neg_sum  = 49'sd0 - $signed({r_sum[47], r_sum});

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_AP: begin
                mul_a = {{2{r_t[31]}}, r_t};
                mul_b = {{2{r_est[31]}}, r_est};
            end
            ST_AP_W: begin
                mul_a = {1'b0, abs_t};
                mul_b = {3'd0, r_var};
            end
            ST_PP: begin
                mul_a = {1'b0, abs_t};
                mul_b = {3'd0, r_tp};
            end
            ST_S: begin
                mul_a = {2'd0, abs_e[31:0]};
                mul_b = {2'd0, abs_e[31:0]};
            end
            ST_FA: begin
                mul_a = {r_e[32], r_e};
                mul_b = {17'd0, r_k};
            end
            ST_FA_W: begin
                mul_a = {17'd0, ONE_Q16 - r_k};
                mul_b = {3'd0, r_pp};
            end
            ST_SQ: begin
                mul_a = {2'd0, r_m};
                mul_b = {2'd0, r_m};
            end
            ST_LN: begin
                mul_a = {13'd0, abs_l2};
                mul_b = LN2_Q32;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_AP;
            ST_AP:   n_state = ST_AP_W;
            ST_AP_W: n_state = ST_TP_W;
            ST_TP_W: n_state = ST_PP;
            ST_PP:   n_state = ST_PP_W;
            ST_PP_W: n_state = ST_S;
            ST_S:    n_state = ST_S_W;
            ST_S_W:  n_state = (r_s == 32'd0) ? ST_FIN : ST_KDIV;
            ST_KDIV: if (r_cnt == 7'd1) n_state = ST_FA;
            ST_FA:   n_state = ST_FA_W;
            ST_FA_W: n_state = ST_FV_W;
            ST_FV_W: n_state = ST_QDIV;
            ST_QDIV: if (r_cnt == 7'd1) n_state = ST_NORM;
            ST_NORM: if (r_m[31]) n_state = ST_SQ;
            ST_SQ:   n_state = ST_SQ_W;
            ST_SQ_W: n_state = (r_cnt == 7'd1) ? ST_LN : ST_SQ;
            ST_LN:   n_state = ST_LN_W;
            ST_LN_W: n_state = ST_SUM;
            ST_SUM:  n_state = ST_FIN;
            ST_FIN:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t      <= 32'sd65536;
            r_q      <= 31'd0;
            r_h      <= 31'd65536;
            r_a0     <= 32'sd0;
            r_p0     <= 31'd65536;
            r_est    <= 32'sd0;
            r_var    <= 31'd0;
            r_sum    <= 48'sd0;
            r_primed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_TRANSITION:  r_t  <= i_cfg_data;
                    REG_STATE_NOISE: r_q  <= i_cfg_data[30:0];
                    REG_OBS_NOISE:   r_h  <= i_cfg_data[30:0];
                    REG_INIT_STATE:  r_a0 <= i_cfg_data;
                    REG_INIT_VAR:    r_p0 <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (accept && (i_obs.restart || !r_primed)) begin
                r_est    <= sat_est({{36{r_a0[31]}}, r_a0});
                r_var    <= sat_var({37'd0, r_p0});
                r_sum    <= 48'sd0;
                r_primed <= 1'b1;
            end
            if (r_state == ST_SUM) begin
                if (sum_next > 49'sd140737488355327) r_sum <= 48'sd140737488355327;
                else if (sum_next < -49'sd140737488355328) r_sum <= -48'sd140737488355328;
                else r_sum <= sum_next[47:0];
            end
            if (out_load) begin
                r_est <= r_fa;
                r_var <= r_fv;
            end
        end
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_z   <= i_obs.obs;
                r_err <= 1'b0;
            end
            ST_AP_W: r_ap <= sat_est(rnd16(r_prod));
            ST_TP_W: begin
                r_tp <= sat_var(rnd16(r_prod));
                r_e  <= $signed({r_z[31], r_z}) - $signed({r_ap[31], r_ap});
            end
            ST_PP_W: r_pp <= sat_var(pp_sum);
            ST_S:    r_s  <= {1'b0, r_pp} + {1'b0, r_h};
            ST_S_W: begin
                r_sq <= r_prod[63:0];
                if (r_s == 32'd0) begin
                    r_err  <= 1'b1;
                    r_k    <= ONE_Q16;
                    r_fa   <= sat_est({{36{r_z[31]}}, r_z});
                    r_fv   <= 31'd0;
                    r_term <= 32'sd0;
                end else begin
                    r_rem <= {1'b0, k_num[47:17]};
                    r_dvd <= {k_num[16:0], 47'd0};
                    r_quo <= '0;
                    r_cnt <= 7'd17;
                end
            end
            ST_KDIV, ST_QDIV: begin
                r_rem <= div_bit ? (div_try[31:0] - r_s) : div_try[31:0];
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_quo <= quo_next[40:0];
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    if (r_state == ST_KDIV) r_k <= quo_next[16:0];
                    else r_qd <= quo_next[40:0];
                end
            end
            ST_FA_W: r_fa <= sat_est($signed({{36{r_ap[31]}}, r_ap}) + rnd16(r_prod));
            ST_FV_W: begin
                r_fv  <= (fv_rnd > 68'sd0) ? fv_rnd[30:0] : 31'd0;
                r_rem <= '0;
                r_dvd <= r_sq;
                r_quo <= '0;
                r_cnt <= 7'd64;
                r_m   <= r_s;
                r_n   <= 5'd31;
            end
            ST_NORM: begin
                // bring the leading one of S to the top
                if (r_m[31]) begin
                    r_m   <= {1'b0, r_m[31:1]};
                    r_cnt <= 7'd16;
                    r_f   <= '0;
                end else begin
                    r_m <= {r_m[30:0], 1'b0};
                    r_n <= r_n - 5'd1;
                end
            end
            ST_SQ_W: begin
                r_cnt <= r_cnt - 7'd1;
                if (sq_top[31]) begin
                    r_m <= {1'b0, sq_top[31:1]};
                    r_f <= {r_f[14:0], 1'b1};
                end else begin
                    r_m <= sq_top;
                    r_f <= {r_f[14:0], 1'b0};
                end
            end
            ST_LN: r_f <= {15'd0, l2[20]};
            ST_LN_W: r_term <= sat_est(term_sum);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_ap   <= r_ap;
            r_o_pp   <= r_pp;
            r_o_fa   <= r_fa;
            r_o_fv   <= r_fv;
            r_o_k    <= r_k;
            r_o_term <= r_term;
            r_o_ll   <= neg_sum[48:1];
            r_o_err  <= r_err;
        end
    end

    assign i_obs.ready = (r_state == ST_IDLE);

    assign o_res.valid           = r_out_valid;
    assign o_res.predicted_state = r_o_ap;
    assign o_res.predicted_var   = r_o_pp;
    assign o_res.filtered_state  = r_o_fa;
    assign o_res.filtered_var    = r_o_fv;
    assign o_res.gain            = r_o_k;
    assign o_res.lik_term        = r_o_term;
    assign o_res.log_likelihood  = r_o_ll;
    assign o_res.div_error       = r_o_err;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_obs.ready)
        else $error("observation accepted while a step is in flight");

    a_err_gain_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.div_error) |-> (o_res.gain == ONE_Q16 &&
            o_res.filtered_var == 31'd0 && o_res.lik_term == 32'd0))
        else $error("zero innovation variance result inconsistent");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.gain <= ONE_Q16))
        else $error("gain above one");

    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.filtered_var <= o_res.predicted_var))
        else $error("filtered variance above predicted variance");

endmodule
`default_nettype wire

// ===== verif/scalar_kalman_filter_channel_tb.sv =====
`timescale 1ns / 1ps
module scalar_kalman_filter_channel_tb;
    import skf_pkg::*;

    typedef struct {
        logic [31:0] obs;
        logic        restart;
    } t_obs_beat;

    typedef struct {
        logic [31:0] predicted_state;
        logic [30:0] predicted_var;
        logic [31:0] filtered_state;
        logic [30:0] filtered_var;
        logic [16:0] gain;
        logic [31:0] lik_term;
        logic [47:0] log_likelihood;
        logic        div_error;
    } t_res_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    skf_obs_if obs_ch ();
    skf_res_if res_ch ();

    scalar_kalman_filter_channel u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_obs      (obs_ch),
        .o_res      (res_ch)
    );

    // filter coefficients and state as seen by the predictor
    longint      coef_t, noise_q, noise_h, init_a, init_p;
    longint      est_a, est_p, term_sum;
    bit          primed;

    t_obs_beat   obs_pending[$];
    t_res_beat   res_expected[$];
    int          mismatches;
    int          obs_sent, res_seen, div_errors, restarts;
    bit          obs_taken;
    bit          tx_idle_on, rx_idle_on, long_hold_req;
    int          tx_gap, rx_hold, quiet_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic longint sat_s(input longint x, input int b);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (b - 1)) - 1;
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    function automatic longint sat_u(input longint x, input int b);
        longint hi;
        hi = (64'sd1 <<< b) - 1;
        return (x > hi) ? hi : ((x < 0) ? 0 : x);
    endfunction

    function automatic longint round16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint ln_of_var(input longint unsigned s);
        int                n;
        longint unsigned   m, f, mag;
        longint            l2;
        n = 0;
        f = 0;
        while (n < 63 && (s >> (n + 1)) != 0) n++;
        m = (n >= 30) ? (s >> (n - 30)) : (s << (30 - n));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'd2147483648) begin
                m = m >> 1;
                f = f * 2 + 1;
            end else begin
                f = f * 2;
            end
        end
        l2 = (longint'(n) - 16) * 65536 + longint'(f);
        mag = (l2 < 0) ? -l2 : l2;
        mag = (mag * 64'd2977044472 + 64'd2147483648) >> 32;
        return (l2 < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // floor(a*a/s) with the quotient clipped to 2^40 at every step
    function automatic longint unsigned sq_over_var(input longint unsigned a,
                                                    input longint unsigned s);
        logic [127:0]    sq;
        longint unsigned r, q;
        sq = 128'(a) * 128'(a);
        r = 0;
        q = 0;
        for (int i = 127; i >= 0; i--) begin
            r = (r << 1) | longint'(sq[i]);
            q = q * 2;
            if (r >= s) begin
                r = r - s;
                q = q + 1;
            end
            if (q > 64'd1099511627776) q = 64'd1099511627776;
        end
        return q;
    endfunction

    function automatic t_res_beat kalman_update(input t_obs_beat b);
        t_res_beat       r;
        longint          z, abs_t, ap, tp, pp, e, fa, fv, term, ll;
        longint unsigned s, k;
        bit              err;
        z = longint'(signed'(b.obs));
        term = 0;
        err = 0;
        if (b.restart || !primed) begin
            est_a = sat_s(init_a, EST_W);
            est_p = sat_u(init_p, VAR_W);
            term_sum = 0;
            primed = 1;
        end
        abs_t = (coef_t < 0) ? -coef_t : coef_t;
        ap = sat_s(round16(coef_t * est_a), EST_W);
        tp = sat_u(round16(abs_t * est_p), VAR_W);
        pp = sat_u(round16(abs_t * tp), VAR_W);
        pp = sat_u(pp + noise_q, VAR_W);
        s = pp + noise_h;
        e = z - ap;
        if (s == 0) begin
            err = 1;
            k = 65536;
            fa = sat_s(z, EST_W);
            fv = 0;
        end else begin
            k = (longint'(pp) * 65536 + s / 2) / s;
            fa = sat_s(ap + round16(e * longint'(k)), EST_W);
            fv = round16((65536 - longint'(k)) * pp);
            term = sat_s(ln_of_var(s) +
                         longint'(sq_over_var((e < 0) ? -e : e, s)), 32);
            term_sum = sat_s(term_sum + term, 48);
        end
        est_a = fa;
        est_p = fv;
        ll = sat_s((-term_sum) >>> 1, 48);
        r.predicted_state = ap[31:0];
        r.predicted_var   = pp[30:0];
        r.filtered_state  = fa[31:0];
        r.filtered_var    = fv[30:0];
        r.gain            = k[16:0];
        r.lik_term        = term[31:0];
        r.log_likelihood  = ll[47:0];
        r.div_error       = err;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                 $time, res_seen, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_TRANSITION:  coef_t  = longint'(signed'(value));
            REG_STATE_NOISE: noise_q = value[30:0];
            REG_OBS_NOISE:   noise_h = value[30:0];
            REG_INIT_STATE:  init_a  = longint'(signed'(value));
            REG_INIT_VAR:    init_p  = value[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (obs_pending.size() != 0 || res_expected.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic push_obs(input logic [31:0] z, input logic rs);
        t_obs_beat b;
        b.obs = z;
        b.restart = rs;
        obs_pending.push_back(b);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic random_setup();
        logic [31:0] t;
        // mostly a sensible transition near +/-1, now and then anything
        if ($urandom_range(0, 3) == 0) t = $urandom;
        else t = $urandom_range(32768, 98304);
        if ($urandom_range(0, 1)) t = -t;
        write_reg(REG_TRANSITION, t);
        write_reg(REG_STATE_NOISE,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536));
        write_reg(REG_OBS_NOISE,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 20));
        write_reg(REG_INIT_STATE, $urandom_range(0, 3) == 0 ? $urandom :
                  $urandom_range(0, 1 << 22) - (1 << 21));
        write_reg(REG_INIT_VAR,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20));
    endtask

    // stimulus driver
    always @(negedge i_clk) begin
        if (i_rst_n && (obs_taken || !obs_ch.valid)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                obs_ch.valid <= 1'b0;
            end else if (tx_idle_on && $urandom_range(0, 4) == 0) begin
                tx_gap = $urandom_range(0, 2);
                obs_ch.valid <= 1'b0;
            end else if (obs_pending.size() != 0) begin
                t_obs_beat b;
                b = obs_pending.pop_front();
                obs_ch.valid   <= 1'b1;
                obs_ch.obs     <= b.obs;
                obs_ch.restart <= b.restart;
            end else begin
                obs_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: short random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 0;
            rx_hold = 1000;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            res_ch.ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(0, 2);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        obs_taken = i_rst_n && obs_ch.valid && obs_ch.ready;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (res_expected.size() == 0) begin
                report_mismatch("result beat with nothing expected, valid", 1, 0);
            end else begin
                t_res_beat w;
                w = res_expected.pop_front();
                if (res_ch.predicted_state !== w.predicted_state)
                    report_mismatch("predicted_state", res_ch.predicted_state,
                                    w.predicted_state);
                if (res_ch.predicted_var !== w.predicted_var)
                    report_mismatch("predicted_var", res_ch.predicted_var,
                                    w.predicted_var);
                if (res_ch.filtered_state !== w.filtered_state)
                    report_mismatch("filtered_state", res_ch.filtered_state,
                                    w.filtered_state);
                if (res_ch.filtered_var !== w.filtered_var)
                    report_mismatch("filtered_var", res_ch.filtered_var,
                                    w.filtered_var);
                if (res_ch.gain !== w.gain)
                    report_mismatch("gain", res_ch.gain, w.gain);
                if (res_ch.lik_term !== w.lik_term)
                    report_mismatch("lik_term", res_ch.lik_term, w.lik_term);
                if (res_ch.log_likelihood !== w.log_likelihood)
                    report_mismatch("log_likelihood", res_ch.log_likelihood,
                                    w.log_likelihood);
                if (res_ch.div_error !== w.div_error)
                    report_mismatch("div_error", res_ch.div_error, w.div_error);
                if (w.div_error) div_errors++;
            end
            res_seen++;
        end
        if (obs_taken) begin
            t_obs_beat b;
            b.obs = obs_ch.obs;
            b.restart = obs_ch.restart;
            res_expected.push_back(kalman_update(b));
            obs_sent++;
            if (b.restart) restarts++;
        end
        if (obs_taken || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= 40000) begin
            $display("timeout waiting for a beat");
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        obs_ch.valid   = 1'b0;
        obs_ch.obs     = '0;
        obs_ch.restart = 1'b0;
        res_ch.ready   = 1'b0;
        coef_t = 65536; noise_q = 0; noise_h = 65536; init_a = 0; init_p = 65536;
        est_a = 0; est_p = 0; term_sum = 0; primed = 0;
        mismatches = 0; obs_sent = 0; res_seen = 0; div_errors = 0; restarts = 0;
        obs_taken = 0; tx_gap = 0; rx_hold = 0; quiet_cycles = 0;
        tx_idle_on = 1; rx_idle_on = 1; long_hold_req = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: field extremes, first beat primes from the initials
        push_obs(32'h0000_0000, 1'b0);
        push_obs(32'h7fff_ffff, 1'b0);
        push_obs(32'h8000_0000, 1'b0);
        push_obs(32'h0001_0000, 1'b1);
        push_obs(32'hffff_0000, 1'b0);
        push_obs(32'hffff_ffff, 1'b0);
        drain();
        // zero innovation variance
        write_reg(REG_OBS_NOISE, 32'h0);
        write_reg(REG_STATE_NOISE, 32'h0);
        write_reg(REG_INIT_VAR, 32'h0);
        write_reg(REG_INIT_STATE, 32'h7fff_ffff);
        push_obs(32'h1234_5678, 1'b1);
        push_obs(32'h8000_0000, 1'b0);
        push_obs(32'h7fff_ffff, 1'b0);
        drain();
        // saturating corners
        write_reg(REG_TRANSITION, 32'h8000_0000);
        write_reg(REG_STATE_NOISE, 32'hffff_ffff);
        write_reg(REG_OBS_NOISE, 32'h7fff_ffff);
        write_reg(REG_INIT_STATE, 32'h8000_0000);
        write_reg(REG_INIT_VAR, 32'hffff_ffff);
        push_obs(32'h7fff_ffff, 1'b1);
        push_obs(32'h8000_0000, 1'b0);
        push_obs(32'h0000_0000, 1'b0);
        drain();
        write_reg(REG_TRANSITION, 32'h7fff_ffff);
        write_reg(REG_STATE_NOISE, 32'h0000_0001);
        write_reg(REG_OBS_NOISE, 32'h0000_0001);
        write_reg(REG_INIT_STATE, 32'h7fff_ffff);
        push_obs(32'h8000_0000, 1'b1);
        push_obs(32'h7fff_ffff, 1'b0);
        push_obs(32'h0000_0001, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            logic [31:0] centre;
            random_setup();
            if (ph == 5) begin
                tx_idle_on = 0;
                rx_idle_on = 0;
            end
            centre = $urandom_range(0, 1 << 22) - (1 << 21);
            for (int i = 0; i < 240; i++) begin
                case ($urandom_range(0, 9))
                    0: push_obs($urandom, $urandom_range(0, 15) == 0);
                    1: push_obs(pick_extreme(), $urandom_range(0, 15) == 0);
                    default: push_obs(centre + $urandom_range(0, 1 << 18) - (1 << 17),
                                      $urandom_range(0, 30) == 0);
                endcase
            end
            if (ph == 1) begin
                repeat (20) @(posedge i_clk);
                long_hold_req = 1;
            end
            drain();
        end

        $display("%0d observations (%0d restarts) over 10 coefficient sets",
                 obs_sent, restarts);
        $display("%0d results checked, %0d with zero innovation variance",
                 res_seen, div_errors);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== scalar_kalman_filter_channel.f =====
rtl/core/skf_pkg.sv
rtl/core/skf_obs_if.sv
rtl/core/skf_res_if.sv
rtl/core/scalar_kalman_filter_channel.sv
verif/scalar_kalman_filter_channel_tb.sv
